>>> hw/rtl/i2cms_pkg.sv
// Shared types and codes for the I2C master byte sequencer.
// No dependencies; used by i2cms_core and i2c_master_byte_sequencer_top.
`default_nettype none

package i2cms_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [11:0] ACK_TIMEOUT_RESET    = 12'd1000;
    localparam logic [9:0]  TICKS_PER_UNIT_RESET = 10'd1;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_ok;
        logic       rejected;
    } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cms_core.sv
// Sequencer state and single-pass next-state logic for one transfer.
// Depends on i2cms_pkg (operation codes, result struct).
`default_nettype none

module i2cms_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [2:0]       operation,
    input  wire logic [7:0]       data_byte,
    input  wire logic             ack_flag,
    input  wire logic             sda_sample,
    input  wire logic [11:0]      ack_timeout,
    input  wire logic [9:0]       ticks_per_unit,
    output i2cms_pkg::res_t       result
);

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic en;
    } lines_t;

    cmd_t        cmd_reg,   cmd_next;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  bits_reg,  bits_next;
    logic [7:0]  shift_reg, shift_next;
    logic [9:0]  unit_reg,  unit_next;
    logic [12:0] poll_reg,  poll_next;
    lines_t      lines_reg, lines_next;
    logic        ackm_reg,  ackm_next;

    logic        is_cmd;
    logic        do_enter;
    logic        fin;
    logic        fin_ok;
    logic [7:0]  fin_byte;
    logic        rej;
    logic [9:0]  tpu_eff;
    logic [10:0] unit_inc;
    logic [3:0]  bits_inc;

    function automatic lines_t enter_lines(input cmd_t c, input logic [2:0] ph,
                                           input logic [7:0] sh, input logic am,
                                           input logic cur_sda);
        lines_t l;
        begin
            l = '{scl: 1'b1, sda: cur_sda, en: 1'b1};
            unique case (c)
                CMD_START:
                begin
                    l = '{scl: (ph < 3'd4), sda: (ph < 3'd2), en: 1'b1};
                end
                CMD_STOP:
                begin
                    l = '{scl: (ph >= 3'd2), sda: (ph >= 3'd4), en: 1'b1};
                end
                CMD_WRITE:
                begin
                    if (ph == 3'd0)
                        l = '{scl: 1'b0, sda: cur_sda, en: 1'b1};
                    else if (ph == 3'd1)
                        l = '{scl: 1'b0, sda: sh[7], en: 1'b1};
                    else if (ph == 3'd2)
                        l = '{scl: 1'b1, sda: cur_sda, en: 1'b1};
                    else if (ph == 3'd3)
                        l = '{scl: 1'b0, sda: 1'b1, en: 1'b0};
                    else if (ph == 3'd4 || ph == 3'd5)
                        l = '{scl: 1'b1, sda: 1'b1, en: 1'b0};
                    else
                        l = '{scl: 1'b0, sda: 1'b1, en: 1'b0};
                end
                CMD_READ:
                begin
                    if (ph == 3'd0)
                        l = '{scl: 1'b1, sda: cur_sda, en: 1'b0};
                    else if (ph == 3'd1)
                        l = '{scl: 1'b0, sda: cur_sda, en: 1'b0};
                    else if (ph == 3'd2)
                        l = '{scl: 1'b0, sda: ~am, en: 1'b1};
                    else if (ph == 3'd3)
                        l = '{scl: 1'b1, sda: cur_sda, en: 1'b1};
                    else
                        l = '{scl: 1'b0, sda: cur_sda, en: 1'b1};
                end
                default:
                begin
                    l = '{scl: 1'b1, sda: cur_sda, en: 1'b1};
                end
            endcase
            return l;
        end
    endfunction

    assign is_cmd   = (operation == i2cms_pkg::OP_START) || (operation == i2cms_pkg::OP_STOP)
                   || (operation == i2cms_pkg::OP_WRITE) || (operation == i2cms_pkg::OP_READ);
    assign tpu_eff  = (ticks_per_unit == 10'd0) ? 10'd1 : ticks_per_unit;
    assign unit_inc = {1'b0, unit_reg} + 11'd1;
    assign bits_inc = bits_reg + 4'd1;

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        unit_next  = unit_reg;
        poll_next  = poll_reg;
        lines_next = lines_reg;
        ackm_next  = ackm_reg;
        do_enter   = 1'b0;
        fin        = 1'b0;
        fin_ok     = 1'b0;
        fin_byte   = 8'd0;
        rej        = 1'b0;

        if (step)
        begin
            if (is_cmd)
            begin
                if (cmd_reg != CMD_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    cmd_next   = cmd_t'(operation);
                    phase_next = 3'd0;
                    bits_next  = 4'd0;
                    unit_next  = 10'd0;
                    poll_next  = 13'd0;
                    ackm_next  = ack_flag;
                    shift_next = (operation == i2cms_pkg::OP_WRITE) ? data_byte : 8'd0;
                    do_enter   = 1'b1;
                end
            end
            else if (cmd_reg != CMD_IDLE)
            begin
                if (cmd_reg == CMD_WRITE && phase_reg == 3'd5)
                begin
                    if (!sda_sample)
                    begin
                        phase_next = 3'd6;
                        unit_next  = 10'd0;
                        do_enter   = 1'b1;
                    end
                    else if (poll_reg > {1'b0, ack_timeout})
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        poll_next = poll_reg + 13'd1;
                    end
                end
                else if (unit_inc >= {1'b0, tpu_eff})
                begin
                    unit_next = 10'd0;
                    unique case (cmd_reg)
                        CMD_START, CMD_STOP:
                        begin
                            if (phase_reg >= 3'd5)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = phase_reg + 3'd1;
                                do_enter   = 1'b1;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (phase_reg == 3'd2)
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bits_next  = bits_inc;
                                if (bits_inc < 4'd8)
                                begin
                                    phase_next = 3'd0;
                                    do_enter   = 1'b1;
                                end
                                else if (ackm_reg)
                                begin
                                    phase_next = 3'd3;
                                    do_enter   = 1'b1;
                                end
                                else
                                begin
                                    lines_next = '{scl: 1'b0, sda: 1'b1, en: 1'b1};
                                    fin        = 1'b1;
                                    fin_ok     = 1'b1;
                                end
                            end
                            else if (phase_reg >= 3'd6)
                            begin
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end
                            else
                            begin
                                phase_next = phase_reg + 3'd1;
                                do_enter   = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (phase_reg == 3'd0)
                            begin
                                shift_next = {shift_reg[6:0], sda_sample};
                                phase_next = 3'd1;
                                do_enter   = 1'b1;
                            end
                            else if (phase_reg == 3'd1)
                            begin
                                bits_next  = bits_inc;
                                phase_next = (bits_inc < 4'd8) ? 3'd0 : 3'd2;
                                do_enter   = 1'b1;
                            end
                            else if (phase_reg >= 3'd4)
                            begin
                                if (ackm_reg)
                                    lines_next = '{scl: 1'b0, sda: 1'b1, en: 1'b1};
                                fin      = 1'b1;
                                fin_byte = shift_reg;
                            end
                            else
                            begin
                                phase_next = phase_reg + 3'd1;
                                do_enter   = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    unit_next = unit_inc[9:0];
                end
            end
        end

        if (do_enter)
            lines_next = enter_lines(cmd_next, phase_next, shift_next, ackm_next,
                                     lines_next.sda);

        if (fin)
        begin
            cmd_next   = CMD_IDLE;
            phase_next = 3'd0;
            bits_next  = 4'd0;
            unit_next  = 10'd0;
            poll_next  = 13'd0;
        end
    end

    always_comb
    begin
        result.scl_level        = lines_next.scl;
        result.sda_level        = lines_next.sda;
        result.sda_drive_enable = lines_next.en;
        result.busy_res         = (cmd_next != CMD_IDLE);
        result.done_res         = fin;
        result.read_byte        = fin_byte;
        result.ack_ok           = fin_ok;
        result.rejected         = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= 3'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            unit_reg  <= 10'd0;
            poll_reg  <= 13'd0;
            lines_reg <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
            ackm_reg  <= 1'b0;
        end
        else
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            unit_reg  <= unit_next;
            poll_reg  <= poll_next;
            lines_reg <= lines_next;
            ackm_reg  <= ackm_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_byte_sequencer_top.sv
// Top level of the I2C master byte sequencer: APB registers, core, result buffer.
// Depends on i2cms_pkg and i2cms_core.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    operation, data_byte, ack_flag, sda_sample
//   result    out_valid / out_ready  scl_level .. rejected, one per input transfer
//   config    psel/penable/pwrite    paddr, pwdata, prdata (ack_timeout @0, ticks @4)
//
// One input transfer per cycle while in_ready is high; its result is registered on the output.
// The core updates in the accept cycle; a result register plus a skid register
// let input keep flowing for one more transfer while the output stalls.
// Reset is asynchronous, active low, and sets the core's lines to SCL high, SDA high, driven.
`default_nettype none

module i2c_master_byte_sequencer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic        ack_flag,
    input  wire logic        sda_sample,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             scl_level,
    output logic             sda_level,
    output logic             sda_drive_enable,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       read_byte,
    output logic             ack_ok,
    output logic             rejected,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [11:0]     timeout_reg;
    logic [9:0]      tpu_reg;
    logic            cfg_wr;
    logic            accept;
    i2cms_pkg::res_t core_res;
    i2cms_pkg::res_t out_reg,   out_next;
    i2cms_pkg::res_t skid_reg,  skid_next;
    logic            out_valid_reg,  out_valid_next;
    logic            skid_valid_reg, skid_valid_next;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = paddr[2] ? {22'd0, tpu_reg} : {20'd0, timeout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= i2cms_pkg::ACK_TIMEOUT_RESET;
            tpu_reg     <= i2cms_pkg::TICKS_PER_UNIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                tpu_reg <= pwdata[9:0];
            else
                timeout_reg <= pwdata[11:0];
        end
    end

    assign in_ready = ~skid_valid_reg;
    assign accept   = in_valid & in_ready;

    i2cms_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .operation      (operation),
        .data_byte      (data_byte),
        .ack_flag       (ack_flag),
        .sda_sample     (sda_sample),
        .ack_timeout    (timeout_reg),
        .ticks_per_unit (tpu_reg),
        .result         (core_res)
    );

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = core_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = core_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign scl_level        = out_reg.scl_level;
    assign sda_level        = out_reg.sda_level;
    assign sda_drive_enable = out_reg.sda_drive_enable;
    assign busy_res         = out_reg.busy_res;
    assign done_res         = out_reg.done_res;
    assign read_byte        = out_reg.read_byte;
    assign ack_ok           = out_reg.ack_ok;
    assign rejected         = out_reg.rejected;

endmodule

`default_nettype wire
